@@ rtl/core/prb_pkg.sv @@
// ----------------------------------------------------------------------------
// prb_pkg
// Shared constants, types and a helper function of the priority ready bitmap.
// ----------------------------------------------------------------------------
package prb_pkg;

    localparam int NUM_LEVELS  = 64;
    localparam int SLOT_DEPTH  = 64;
    localparam int SLOT_AW     = $clog2(SLOT_DEPTH);
    localparam int ROW_COUNT   = 8;
    localparam int ROW_AW      = $clog2(ROW_COUNT);
    localparam int HANDLE_W    = 8;
    localparam int PRIO_W      = 8;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [PRIO_W-1:0] IDLE_PRIO_RESET = 8'd63;

    typedef struct packed {
        logic accept;
        logic exec;
    } prb_cmd_t;

    function automatic logic [ROW_AW-1:0] lowest_bit(input logic [ROW_COUNT-1:0] v);
        logic [ROW_AW-1:0] pos;
        logic              found;
        pos   = '0;
        found = 1'b0;
        for (int n = 0; n < ROW_COUNT; n++)
        begin
            if (v[n] && !found)
            begin
                pos   = ROW_AW'(n);
                found = 1'b1;
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/core/prb_ram.sv @@
// ----------------------------------------------------------------------------
// prb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prb_ram #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 64,
    parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_WIDTH-1:0] waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [ADDR_WIDTH-1:0] raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/prb_ctrl.sv @@
// ----------------------------------------------------------------------------
// prb_ctrl
// Sequencer: accept a request, run the update step, then present the result.
// ----------------------------------------------------------------------------
module prb_ctrl import prb_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     result_valid,
    output prb_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);
    assign cmd.accept   = (state_reg == ST_IDLE) && start;
    assign cmd.exec     = (state_reg == ST_EXEC);

endmodule

@@ rtl/core/prb_datapath.sv @@
// ----------------------------------------------------------------------------
// prb_datapath
// Slot store, two-level ready bitmap, update logic and best-priority search.
// ----------------------------------------------------------------------------
module prb_datapath import prb_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  prb_cmd_t            cmd,
    input  logic [1:0]          kind,
    input  logic [PRIO_W-1:0]   priority_req,
    input  logic [HANDLE_W-1:0] task_handle,
    input  logic                cfg_we,
    input  logic [PRIO_W-1:0]   cfg_data,
    output logic                status,
    output logic [HANDLE_W-1:0] removed_handle,
    output logic [PRIO_W-1:0]   best_priority,
    output logic                none_ready
);

    logic [1:0]           kind_reg;
    logic [PRIO_W-1:0]    prio_reg;
    logic [HANDLE_W-1:0]  handle_reg;
    logic [PRIO_W-1:0]    idle_reg;
    logic [ROW_COUNT-1:0] row_bits_reg [ROW_COUNT];
    logic [ROW_COUNT-1:0] row_bits_next [ROW_COUNT];
    logic [ROW_COUNT-1:0] group_reg;
    logic [ROW_COUNT-1:0] group_next;
    logic                 status_reg;
    logic                 status_next;
    logic [HANDLE_W-1:0]  removed_reg;
    logic [HANDLE_W-1:0]  removed_next;

    logic [HANDLE_W-1:0]  slot_rdata;
    logic                 ram_we;
    logic [ROW_AW-1:0]    row_sel;
    logic [ROW_AW-1:0]    bit_sel;
    logic                 in_range;
    logic                 occupied;
    logic [ROW_AW-1:0]    best_row;
    logic [ROW_AW-1:0]    best_bit;

    prb_ram #(
        .DATA_WIDTH(HANDLE_W),
        .DEPTH     (SLOT_DEPTH)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(prio_reg[SLOT_AW-1:0]),
        .wdata(handle_reg),
        .re   (cmd.accept),
        .raddr(priority_req[SLOT_AW-1:0]),
        .rdata(slot_rdata)
    );

    assign row_sel  = prio_reg[SLOT_AW-1:ROW_AW];
    assign bit_sel  = prio_reg[ROW_AW-1:0];
    assign in_range = (prio_reg < PRIO_W'(NUM_LEVELS));
    assign occupied = in_range && row_bits_reg[row_sel][bit_sel];

    always_comb
    begin
        row_bits_next = row_bits_reg;
        group_next    = group_reg;
        status_next   = 1'b0;
        removed_next  = '0;
        ram_we        = 1'b0;
        case (kind_reg)
            KIND_ADD:
            begin
                if (!in_range || handle_reg == '0 || occupied)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    row_bits_next[row_sel][bit_sel] = 1'b1;
                    group_next[row_sel]             = 1'b1;
                    ram_we                          = cmd.exec;
                end
            end
            KIND_REMOVE:
            begin
                if (!occupied)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    row_bits_next[row_sel][bit_sel] = 1'b0;
                    if (row_bits_next[row_sel] == '0)
                    begin
                        group_next[row_sel] = 1'b0;
                    end
                    removed_next = slot_rdata;
                end
            end
            default:
            begin
                status_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= kind;
            prio_reg   <= priority_req;
            handle_reg <= task_handle;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                row_bits_reg[r] <= '0;
            end
            group_reg <= '0;
            idle_reg  <= IDLE_PRIO_RESET;
        end
        else
        begin
            if (cmd.exec)
            begin
                row_bits_reg <= row_bits_next;
                group_reg    <= group_next;
            end
            if (cfg_we)
            begin
                idle_reg <= cfg_data;
            end
        end
    end

    assign best_row       = lowest_bit(group_reg);
    assign best_bit       = lowest_bit(row_bits_reg[best_row]);
    assign none_ready     = (group_reg == '0);
    assign best_priority  = none_ready ? idle_reg
                                       : PRIO_W'({best_row, best_bit});
    assign status         = status_reg;
    assign removed_handle = removed_reg;

endmodule

@@ rtl/core/priority_ready_bitmap.sv @@
// ----------------------------------------------------------------------------
// priority_ready_bitmap
// Ready list with one slot per priority level and a two-level ready bitmap.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  request   start, busy, kind, priority_req, task_handle   in (busy out)
//  result    result_valid, status, removed_handle,          out
//            best_priority, none_ready
//  config    cfg_valid, cfg_ready, cfg_data                 in (ready out)
//
//  A request beat runs through accept, update and result. The slot RAM
//  is read at accept and its registered data feeds the update cycle.
//  The result is shown for one cycle with result_valid; busy is high
//  from the cycle after accept through the result cycle.
//  The receiver cannot stall, so the sender waits only on busy.
//  Reset clears all ready bits; a slot whose bit is clear reads as empty.
// ----------------------------------------------------------------------------
module priority_ready_bitmap import prb_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          kind,
    input  logic [PRIO_W-1:0]   priority_req,
    input  logic [HANDLE_W-1:0] task_handle,
    output logic                result_valid,
    output logic                status,
    output logic [HANDLE_W-1:0] removed_handle,
    output logic [PRIO_W-1:0]   best_priority,
    output logic                none_ready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PRIO_W-1:0]   cfg_data
);

    prb_cmd_t cmd;

    assign cfg_ready = 1'b1;

    prb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .result_valid(result_valid),
        .cmd         (cmd)
    );

    prb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .kind          (kind),
        .priority_req  (priority_req),
        .task_handle   (task_handle),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .status        (status),
        .removed_handle(removed_handle),
        .best_priority (best_priority),
        .none_ready    (none_ready)
    );

endmodule

@@ dv/priority_ready_bitmap_tb.sv @@
// ----------------------------------------------------------------------------
// priority_ready_bitmap_tb
// Self-checking testbench for the priority ready bitmap. Directed requests
// cover the edges of the list and every reject case, then random traffic
// fills and drains it under several idle priority settings. A predictor
// tracks slots and bitmaps, and each result beat is checked field by field.
// ----------------------------------------------------------------------------
module priority_ready_bitmap_tb import prb_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         GAP_LONG_MAX = 20;
    localparam int         PRINT_LIMIT  = 40;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] removed_handle;
        logic [PRIO_W-1:0]   best_priority;
        logic                none_ready;
    } ready_result_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic [1:0]          kind           = KIND_QUERY;
    logic [PRIO_W-1:0]   priority_req   = '0;
    logic [HANDLE_W-1:0] task_handle    = '0;
    logic                result_valid;
    logic                status;
    logic [HANDLE_W-1:0] removed_handle;
    logic [PRIO_W-1:0]   best_priority;
    logic                none_ready;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [PRIO_W-1:0]   cfg_data       = '0;

    logic [HANDLE_W-1:0]  slot_handle_m [SLOT_DEPTH];
    logic [ROW_COUNT-1:0] row_bits_m    [ROW_COUNT];
    logic [ROW_COUNT-1:0] group_bits_m;
    logic [PRIO_W-1:0]    idle_prio_m;

    ready_result_t expected_q[$];
    int            pending     = 0;
    int            mismatches  = 0;
    int            n_sent      = 0;
    int            n_checked   = 0;
    int            n_add_ok    = 0;
    int            n_remove_ok = 0;
    int            n_reject    = 0;
    int            n_query     = 0;
    int            n_cfg       = 0;

    always #5 clk = ~clk;

    priority_ready_bitmap u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .priority_req   (priority_req),
        .task_handle    (task_handle),
        .result_valid   (result_valid),
        .status         (status),
        .removed_handle (removed_handle),
        .best_priority  (best_priority),
        .none_ready     (none_ready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    function automatic int first_set(input logic [ROW_COUNT-1:0] v);
        for (int n = 0; n < ROW_COUNT; n++)
        begin
            if (v[n])
                return n;
        end
        return 0;
    endfunction

    function automatic ready_result_t apply_request(input logic [1:0]          k,
                                                    input logic [PRIO_W-1:0]   p,
                                                    input logic [HANDLE_W-1:0] h);
        ready_result_t     r;
        logic              in_range;
        logic [ROW_AW-1:0] row;
        logic [ROW_AW-1:0] bit_pos;
        logic [ROW_AW-1:0] best_row;
        r        = '0;
        in_range = (p < NUM_LEVELS);
        row      = p[SLOT_AW-1:ROW_AW];
        bit_pos  = p[ROW_AW-1:0];
        if (k == KIND_ADD)
        begin
            if (!in_range || h == '0)
            begin
                r.status = 1'b1;
                n_reject++;
            end
            else if (slot_handle_m[p[SLOT_AW-1:0]] != '0)
            begin
                r.status = 1'b1;
                n_reject++;
            end
            else
            begin
                slot_handle_m[p[SLOT_AW-1:0]] = h;
                row_bits_m[row]      = row_bits_m[row] | (ROW_COUNT'(1) << bit_pos);
                group_bits_m         = group_bits_m | (ROW_COUNT'(1) << row);
                n_add_ok++;
            end
        end
        else if (k == KIND_REMOVE)
        begin
            if (!in_range)
            begin
                r.status = 1'b1;
                n_reject++;
            end
            else if (slot_handle_m[p[SLOT_AW-1:0]] == '0)
            begin
                r.status = 1'b1;
                n_reject++;
            end
            else
            begin
                r.removed_handle = slot_handle_m[p[SLOT_AW-1:0]];
                slot_handle_m[p[SLOT_AW-1:0]] = '0;
                row_bits_m[row]  = row_bits_m[row] & ~(ROW_COUNT'(1) << bit_pos);
                if (row_bits_m[row] == '0)
                    group_bits_m = group_bits_m & ~(ROW_COUNT'(1) << row);
                n_remove_ok++;
            end
        end
        else
        begin
            n_query++;
        end
        if (group_bits_m == '0)
        begin
            r.best_priority = idle_prio_m;
            r.none_ready    = 1'b1;
        end
        else
        begin
            best_row        = ROW_AW'(first_set(group_bits_m));
            r.best_priority = PRIO_W'(int'(best_row) * 8 + first_set(row_bits_m[best_row]));
            r.none_ready    = 1'b0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : result_check
        ready_result_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_q.size() == 0)
            begin
                flag_mismatch("result beat with no request outstanding");
            end
            else
            begin
                want = expected_q.pop_front();
                pending--;
                n_checked++;
                if (status !== want.status)
                    flag_mismatch($sformatf("status got %b want %b", status, want.status));
                if (removed_handle !== want.removed_handle)
                    flag_mismatch($sformatf("removed_handle got %0d want %0d",
                                            removed_handle, want.removed_handle));
                if (best_priority !== want.best_priority)
                    flag_mismatch($sformatf("best_priority got %0d want %0d",
                                            best_priority, want.best_priority));
                if (none_ready !== want.none_ready)
                    flag_mismatch($sformatf("none_ready got %b want %b",
                                            none_ready, want.none_ready));
            end
        end
    end

    task automatic send_request(input logic [1:0]          k,
                                input logic [PRIO_W-1:0]   p,
                                input logic [HANDLE_W-1:0] h,
                                input int                  gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        priority_req <= p;
        task_handle  <= h;
        do @(posedge clk); while (busy !== 1'b0);
        expected_q.push_back(apply_request(k, p, h));
        pending++;
        n_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic write_idle_priority(input logic [PRIO_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid   <= 1'b0;
        idle_prio_m  = value;
        n_cfg++;
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, GAP_LONG_MAX);
    endfunction

    task automatic test_empty_list();
        send_request(KIND_QUERY, 8'd0, 8'd0, 0);
        send_request(KIND_UNUSED, 8'd255, 8'd255, 1);
        send_request(KIND_REMOVE, 8'd0, 8'd0, 0);
        wait_drained();
    endtask

    task automatic test_idle_priority_extremes();
        write_idle_priority(8'd0);
        send_request(KIND_QUERY, 8'd17, 8'd3, 0);
        write_idle_priority(8'd255);
        send_request(KIND_QUERY, 8'd0, 8'd0, 0);
        write_idle_priority(IDLE_PRIO_RESET);
        send_request(KIND_UNUSED, 8'd63, 8'd1, 2);
        wait_drained();
    endtask

    task automatic test_add_remove_edges();
        send_request(KIND_ADD,    8'd0,   8'd255, 0);
        send_request(KIND_ADD,    8'd63,  8'd1,   0);
        send_request(KIND_ADD,    8'd7,   8'h80,  1);
        send_request(KIND_ADD,    8'd8,   8'h7f,  0);
        send_request(KIND_ADD,    8'd0,   8'd5,   0);
        send_request(KIND_ADD,    8'd10,  8'd0,   0);
        send_request(KIND_ADD,    8'd64,  8'd9,   2);
        send_request(KIND_ADD,    8'd255, 8'd9,   0);
        send_request(KIND_REMOVE, 8'd200, 8'd0,   0);
        send_request(KIND_REMOVE, 8'd5,   8'd0,   1);
        send_request(KIND_QUERY,  8'd0,   8'd0,   0);
        send_request(KIND_REMOVE, 8'd0,   8'd0,   0);
        send_request(KIND_REMOVE, 8'd7,   8'd0,   0);
        send_request(KIND_REMOVE, 8'd8,   8'd0,   3);
        send_request(KIND_REMOVE, 8'd63,  8'd0,   0);
        send_request(KIND_REMOVE, 8'd63,  8'd0,   0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int                count,
                                       input int                add_pct,
                                       input logic [PRIO_W-1:0] idle_value,
                                       input bit                calm,
                                       input bit                pauses);
        logic [1:0]          k;
        logic [PRIO_W-1:0]   p;
        logic [HANDLE_W-1:0] h;
        int                  r;
        int                  origin;
        int                  idx;
        bit                  found;
        write_idle_priority(idle_value);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            h = '0;
            if (r < add_pct)
            begin
                k = KIND_ADD;
                h = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                if ($urandom_range(0, 99) < 85)
                    p = 8'($urandom_range(0, NUM_LEVELS - 1));
                else
                    p = 8'($urandom_range(NUM_LEVELS, 255));
            end
            else if (r < 90)
            begin
                k = KIND_REMOVE;
                if ($urandom_range(0, 99) < 75)
                begin
                    origin = $urandom_range(0, SLOT_DEPTH - 1);
                    found  = 1'b0;
                    p      = 8'(origin);
                    for (int j = 0; j < SLOT_DEPTH; j++)
                    begin
                        idx = (origin + j) % SLOT_DEPTH;
                        if (!found && slot_handle_m[idx[SLOT_AW-1:0]] != '0)
                        begin
                            p     = 8'(idx);
                            found = 1'b1;
                        end
                    end
                end
                else
                begin
                    p = 8'($urandom_range(0, 255));
                end
                h = 8'($urandom_range(0, 255));
            end
            else
            begin
                k = ($urandom_range(0, 1) == 0) ? KIND_QUERY : KIND_UNUSED;
                p = 8'($urandom_range(0, 255));
                h = 8'($urandom_range(0, 255));
            end
            if (pauses && $urandom_range(0, 29) == 0)
                wait_drained();
            send_request(k, p, h, pick_gap(calm));
        end
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < SLOT_DEPTH; i++)
            slot_handle_m[i] = '0;
        for (int i = 0; i < ROW_COUNT; i++)
            row_bits_m[i] = '0;
        group_bits_m = '0;
        idle_prio_m  = IDLE_PRIO_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_idle_priority_extremes();
        test_add_remove_edges();
        test_random_traffic(130, 70, 8'd0,   1'b0, 1'b0);
        test_random_traffic(130, 30, 8'd255, 1'b1, 1'b0);
        test_random_traffic(140, 45, 8'($urandom_range(1, 254)), 1'b0, 1'b1);
        test_random_traffic(130, 50, IDLE_PRIO_RESET, 1'b0, 1'b1);

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_q.size()));

        $display("Covered %0d requests, %0d results checked: %0d adds, %0d removes, %0d rejects,",
                 n_sent, n_checked, n_add_ok, n_remove_ok, n_reject);
        $display("%0d queries, %0d idle priority writes; %0d mismatches.",
                 n_query, n_cfg, mismatches);
        if (mismatches == 0)
            $display("** priority_ready_bitmap: PASSED **");
        else
            $display("** priority_ready_bitmap: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", pending);
        $display("** priority_ready_bitmap: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/prb_pkg.sv
rtl/core/prb_ram.sv
rtl/core/prb_ctrl.sv
rtl/core/prb_datapath.sv
rtl/core/priority_ready_bitmap.sv
dv/priority_ready_bitmap_tb.sv
